// ===== hw/rtl/bdlp_pkg.sv =====
// Shared types, codes and helpers for the button debounce and long-press block.
package bdlp_pkg;

    // Width of the threshold registers and of the drop counter.
    localparam int unsigned CFG_W = 16;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [2:0] REG_MAX_DROP_COUNT   = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_TICKS = 3'd2;
    localparam logic [2:0] REG_VIBRATE_ENABLE   = 3'd3;
    localparam logic [2:0] REG_SOUND_ENABLE     = 3'd4;

    // Event codes.
    localparam logic [2:0] EVT_LONG  = 3'd0;
    localparam logic [2:0] EVT_GREEN = 3'd1;
    localparam logic [2:0] EVT_AMBER = 3'd2;
    localparam logic [2:0] EVT_RED   = 3'd3;
    localparam logic [2:0] EVT_NONE  = 3'd4;

    // Feedback codes.
    localparam logic [1:0] FB_NONE    = 2'd0;
    localparam logic [1:0] FB_VIBRATE = 2'd1;
    localparam logic [1:0] FB_BEEP    = 2'd2;

    // Press tracking phase.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    // Configuration registers as seen by the press logic.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] max_drop_count;
        logic [CFG_W-1:0] long_press_ticks;
        logic             vibrate_enable;
        logic             sound_enable;
    } cfg_t;

    // One tick item.
    typedef struct packed {
        logic red_level;
        logic amber_level;
        logic green_level;
        logic any_level;
        logic press_edge;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0] feedback;
        logic [2:0] event_code;
    } result_t;

    // Highest-priority latched colour: green, then amber, then red.
    function automatic logic [2:0] color_code(input logic [2:0] colors);
        logic [2:0] code;
        begin
            if (colors[0])
            begin
                code = EVT_GREEN;
            end
            else if (colors[1])
            begin
                code = EVT_AMBER;
            end
            else if (colors[2])
            begin
                code = EVT_RED;
            end
            else
            begin
                code = EVT_NONE;
            end
            return code;
        end
    endfunction

endpackage

// ===== hw/rtl/bdlp_cfg.sv =====
// Configuration register file for the button debounce and long-press block.
module bdlp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [2:0]                    cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]    cfg_wdata,
    output bdlp_pkg::cfg_t                cfg
);

    bdlp_pkg::cfg_t cfg_reg;

    // Registers are written on any cycle with the write enable high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= 16'd50;
            cfg_reg.max_drop_count   <= 16'd10;
            cfg_reg.long_press_ticks <= 16'd1000;
            cfg_reg.vibrate_enable   <= 1'b0;
            cfg_reg.sound_enable     <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bdlp_pkg::REG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= cfg_wdata;
                bdlp_pkg::REG_MAX_DROP_COUNT:   cfg_reg.max_drop_count   <= cfg_wdata;
                bdlp_pkg::REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_wdata;
                bdlp_pkg::REG_VIBRATE_ENABLE:   cfg_reg.vibrate_enable   <= cfg_wdata[0];
                bdlp_pkg::REG_SOUND_ENABLE:     cfg_reg.sound_enable     <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bdlp_core.sv =====
// Press tracking state and the per-tick decision logic.
module bdlp_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bdlp_pkg::item_t     item,
    input  bdlp_pkg::cfg_t      cfg,
    output logic                res_valid,
    output bdlp_pkg::result_t   res
);

    localparam int unsigned CMP_W =
        (TIMER_WIDTH > bdlp_pkg::CFG_W) ? TIMER_WIDTH : bdlp_pkg::CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [bdlp_pkg::CFG_W-1:0] DROP_MAX = {bdlp_pkg::CFG_W{1'b1}};

    bdlp_pkg::phase_t              phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]        elapsed_reg, elapsed_next;
    logic [bdlp_pkg::CFG_W-1:0]    drop_reg, drop_next;
    logic [2:0]                    colors_reg, colors_next;

    // Elapsed time below a threshold that is clamped to the timer's maximum.
    function automatic logic below(input logic [TIMER_WIDTH-1:0] e,
                                   input logic [bdlp_pkg::CFG_W-1:0] th);
        begin
            return (CMP_W'(e) < CMP_W'(th)) && (e != TIMER_MAX);
        end
    endfunction

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bdlp_pkg::PH_IDLE;
            elapsed_reg <= '0;
            drop_reg    <= '0;
            colors_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            drop_reg    <= drop_next;
            colors_reg  <= colors_next;
        end
    end

    // One tick: start a press, count drops in the window, then wait for release or long press.
    always_comb
    begin
        bdlp_pkg::phase_t           ph;
        logic [TIMER_WIDTH-1:0]     e;
        logic [bdlp_pkg::CFG_W-1:0] d;
        logic [2:0]                 c;
        logic                       go;
        logic                       fin;
        logic [2:0]                 code;
        logic [1:0]                 fb;

        ph   = phase_reg;
        e    = elapsed_reg;
        d    = drop_reg;
        c    = colors_reg;
        go   = step;
        fin  = 1'b0;
        code = bdlp_pkg::EVT_NONE;
        fb   = bdlp_pkg::FB_NONE;

        if (step)
        begin
            case (phase_reg)
                bdlp_pkg::PH_DEBOUNCE, bdlp_pkg::PH_HOLD:
                begin
                    if (elapsed_reg != TIMER_MAX)
                    begin
                        e = elapsed_reg + 1'b1;
                    end
                end
                default:
                begin
                    ph = bdlp_pkg::PH_IDLE;
                    if (!item.press_edge)
                    begin
                        go = 1'b0;
                    end
                    else
                    begin
                        c  = {item.red_level, item.amber_level, item.green_level};
                        e  = '0;
                        d  = '0;
                        ph = bdlp_pkg::PH_DEBOUNCE;
                    end
                end
            endcase

            // Debounce window and the judgement at its end.
            if (go && ph == bdlp_pkg::PH_DEBOUNCE)
            begin
                if (below(e, cfg.debounce_ticks))
                begin
                    if (!item.any_level && d != DROP_MAX)
                    begin
                        d = d + 1'b1;
                    end
                    go = 1'b0;
                end
                else if (d > cfg.max_drop_count)
                begin
                    fin  = 1'b1;
                    code = bdlp_pkg::EVT_NONE;
                    go   = 1'b0;
                end
                else
                begin
                    ph = bdlp_pkg::PH_HOLD;
                end
            end

            // Hold: release gives the colour, held at the long-press time gives feedback.
            if (go)
            begin
                fin = 1'b1;
                if (below(e, cfg.long_press_ticks))
                begin
                    if (item.any_level)
                    begin
                        fin = 1'b0;
                    end
                    else
                    begin
                        code = bdlp_pkg::color_code(c);
                    end
                end
                else if (item.any_level)
                begin
                    code = bdlp_pkg::EVT_LONG;
                    if (cfg.vibrate_enable)
                    begin
                        fb = bdlp_pkg::FB_VIBRATE;
                    end
                    else if (cfg.sound_enable)
                    begin
                        fb = bdlp_pkg::FB_BEEP;
                    end
                end
                else
                begin
                    code = bdlp_pkg::color_code(c);
                end
            end

            if (fin)
            begin
                ph = bdlp_pkg::PH_IDLE;
                e  = '0;
                d  = '0;
                c  = '0;
            end
        end

        phase_next     = ph;
        elapsed_next   = e;
        drop_next      = d;
        colors_next    = c;
        res_valid      = fin;
        res.event_code = code;
        res.feedback   = fb;
    end

endmodule

// ===== hw/rtl/button_debounce_long_press.sv =====
// Top level of the button debounce and long-press block.
//
// Each item is one millisecond tick. An item is captured in an input register
// and processed, against the press state, into the result register once that
// register is free or being emptied, so one item is taken every cycle while the
// result side takes results; a result waiting in the result register stalls the
// processing of the held item, and with it the taking of the item behind it.
// A tick gives at most one result: the end of a press (colour code, long press
// with feedback, or no valid press). Ticks that give no result produce nothing
// on the output. Configuration registers may be written only while no item is
// in flight; a change made during a press applies from the next tick.
module button_debounce_long_press #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_wen,
    input  logic [2:0]                    cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]    cfg_wdata,
    // Tick items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // press_edge, any_level, green_level,
                                                     // amber_level, red_level, 3 zero bits
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata    // event_code[2:0], feedback[1:0],
                                                     // 3 zero bits
);

    bdlp_pkg::cfg_t     cfg;
    bdlp_pkg::item_t    in_item_reg;
    logic               in_valid_reg;
    logic               advance;
    logic               res_valid;
    bdlp_pkg::result_t  res;
    bdlp_pkg::result_t  out_res_reg;
    logic               out_valid_reg;

    bdlp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= bdlp_pkg::item_t'(s_tdata[4:0]);
        end
    end

    bdlp_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

endmodule

// ===== dv/button_debounce_long_press_tb.sv =====
// Self-checking testbench for the button debounce and long-press block.
module button_debounce_long_press_tb;

    // Cycles with no item moving on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 400;

    // Tracks the press state from the accepted ticks and holds the events still owed.
    class press_tracker;
        logic [bdlp_pkg::CFG_W-1:0] debounce_ticks;
        logic [bdlp_pkg::CFG_W-1:0] max_drop_count;
        logic [bdlp_pkg::CFG_W-1:0] long_press_ticks;
        logic                       vibrate_enable;
        logic                       sound_enable;

        bdlp_pkg::phase_t           ph;
        logic [15:0]                elapsed;
        logic [15:0]                drops;
        logic [2:0]                 colours;

        bdlp_pkg::result_t          owed_events[$];
        int                         errors;

        function new();
            debounce_ticks   = 16'd50;
            max_drop_count   = 16'd10;
            long_press_ticks = 16'd1000;
            vibrate_enable   = 1'b0;
            sound_enable     = 1'b0;
            ph               = bdlp_pkg::PH_IDLE;
            elapsed          = '0;
            drops            = '0;
            colours          = '0;
            errors           = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [bdlp_pkg::CFG_W-1:0] val);
            case (idx)
                bdlp_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks   = val;
                bdlp_pkg::REG_MAX_DROP_COUNT:   max_drop_count   = val;
                bdlp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks = val;
                bdlp_pkg::REG_VIBRATE_ENABLE:   vibrate_enable   = val[0];
                bdlp_pkg::REG_SOUND_ENABLE:     sound_enable     = val[0];
                default: ;
            endcase
        endfunction

        function bit busy();
            return ph == bdlp_pkg::PH_DEBOUNCE || ph == bdlp_pkg::PH_HOLD;
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        // Green wins over amber, amber over red; nothing latched means no press.
        function logic [2:0] latched_event();
            logic [2:0] code;
            if (colours[0])
            begin
                code = bdlp_pkg::EVT_GREEN;
            end
            else if (colours[1])
            begin
                code = bdlp_pkg::EVT_AMBER;
            end
            else if (colours[2])
            begin
                code = bdlp_pkg::EVT_RED;
            end
            else
            begin
                code = bdlp_pkg::EVT_NONE;
            end
            return code;
        endfunction

        // Ending a press owes one event and clears the press state.
        function void end_press(logic [2:0] code, logic [1:0] fb);
            bdlp_pkg::result_t ev;
            ev.event_code = code;
            ev.feedback   = fb;
            owed_events.push_back(ev);
            ph      = bdlp_pkg::PH_IDLE;
            colours = '0;
            elapsed = '0;
            drops   = '0;
        endfunction

        // Advances the press state by one tick; returns 1 when the tick was not ignored.
        function bit take_tick(bdlp_pkg::item_t it);
            logic [1:0] fb;
            if (!busy())
            begin
                ph = bdlp_pkg::PH_IDLE;
                if (!it.press_edge)
                begin
                    return 1'b0;
                end
                colours = {it.red_level, it.amber_level, it.green_level};
                elapsed = '0;
                drops   = '0;
                ph      = bdlp_pkg::PH_DEBOUNCE;
            end
            else if (elapsed != 16'hFFFF)
            begin
                elapsed = elapsed + 16'd1;
            end

            // Debounce window: count low samples, then judge on the closing tick.
            if (ph == bdlp_pkg::PH_DEBOUNCE)
            begin
                if (elapsed < debounce_ticks)
                begin
                    if (!it.any_level && drops != 16'hFFFF)
                    begin
                        drops = drops + 16'd1;
                    end
                    return 1'b1;
                end
                if (drops > max_drop_count)
                begin
                    end_press(bdlp_pkg::EVT_NONE, bdlp_pkg::FB_NONE);
                    return 1'b1;
                end
                ph = bdlp_pkg::PH_HOLD;
            end

            // Hold: a release before the long-press time reports the colour; held at or past it gives a long press.
            if (elapsed < long_press_ticks)
            begin
                if (!it.any_level)
                begin
                    end_press(latched_event(), bdlp_pkg::FB_NONE);
                end
                return 1'b1;
            end
            if (it.any_level)
            begin
                fb = vibrate_enable ? bdlp_pkg::FB_VIBRATE :
                     (sound_enable ? bdlp_pkg::FB_BEEP : bdlp_pkg::FB_NONE);
                end_press(bdlp_pkg::EVT_LONG, fb);
            end
            else
            begin
                end_press(latched_event(), bdlp_pkg::FB_NONE);
            end
            return 1'b1;
        endfunction

        function void check_event(logic [7:0] data);
            bdlp_pkg::result_t got;
            bdlp_pkg::result_t want;
            got = bdlp_pkg::result_t'(data[4:0]);
            if (owed_events.size() == 0)
            begin
                errors++;
                $display("%0t: event with none owed: expected nothing, actual code %0d fb %0d",
                         $time, got.event_code, got.feedback);
                return;
            end
            want = owed_events.pop_front();
            if (got.event_code !== want.event_code)
            begin
                errors++;
                $display("%0t: event_code mismatch: expected %0d, actual %0d",
                         $time, want.event_code, got.event_code);
            end
            if (got.feedback !== want.feedback)
            begin
                errors++;
                $display("%0t: feedback mismatch: expected %0d, actual %0d",
                         $time, want.feedback, got.feedback);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wen;
    logic [2:0]                 cfg_index;
    logic [bdlp_pkg::CFG_W-1:0] cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;   // press_edge, any_level, green_level,
                                           // amber_level, red_level
    logic                       m_tvalid;
    logic                       m_tready;
    logic [7:0]                 m_tdata;   // event_code[2:0], feedback[1:0]

    press_tracker               tracker;
    int                         useful_ticks;
    bit                         calm;
    int                         src_gap_pct;
    int                         snk_gap_pct;
    int                         snk_stall;
    int                         quiet_cycles;

    button_debounce_long_press DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // Result side: random stall bursts, none once the run is in its calm stretch.
    always @(posedge clk)
    begin
        if (calm || snk_gap_pct == 0)
        begin
            snk_stall = 0;
            m_tready <= 1'b1;
        end
        else if (snk_stall > 0)
        begin
            snk_stall--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(1, 100) <= snk_gap_pct)
        begin
            snk_stall = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted result is checked against the oldest owed event.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            tracker.check_event(m_tdata);
        end
    end

    // Watchdog on cycles in which no item moves.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("button_debounce_long_press_tb NOT OK");
                $finish;
            end
        end
    end

    // Offers one tick, possibly after a random gap, and waits for it to be taken.
    task automatic send_tick(input logic pe, input logic any, input logic [2:0] cols);
        bdlp_pkg::item_t it;
        int              gap;
        it.press_edge  = pe;
        it.any_level   = any;
        it.green_level = cols[0];
        it.amber_level = cols[1];
        it.red_level   = cols[2];
        if (!calm && src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (tracker.take_tick(it))
        begin
            useful_ticks++;
        end
    endtask

    // Holds the source off until every owed event has come back.
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all five registers once the block has settled.
    task automatic write_config(input logic [15:0] deb, input logic [15:0] drop,
                                input logic [15:0] lng, input logic vib, input logic snd);
        logic [bdlp_pkg::CFG_W-1:0] vals[5];
        vals[0] = deb;
        vals[1] = drop;
        vals[2] = lng;
        vals[3] = {15'd0, vib};
        vals[4] = {15'd0, snd};
        drain_events();
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_wen   <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            tracker.set_reg(3'(i), vals[i]);
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Released ticks, with stray edges and colours, until the press has ended.
    task automatic release_press();
        while (tracker.busy())
        begin
            send_tick($urandom_range(0, 7) == 0, 1'b0, 3'($urandom));
        end
    endtask

    // Ticks between presses that carry no edge.
    task automatic idle_ticks();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) send_tick(1'b0, 1'($urandom), 3'($urandom));
    endtask

    // One press: bouncing debounce window, hold of random length, then release.
    task automatic random_press();
        int drop_pct;
        int hold_len;
        int n;
        case ($urandom_range(0, 2))
            0:       drop_pct = 0;
            1:       drop_pct = 20;
            default: drop_pct = 70;
        endcase
        send_tick(1'b1, $urandom_range(0, 99) >= drop_pct, 3'($urandom));
        n = 0;
        while (tracker.busy() && n < int'(tracker.debounce_ticks))
        begin
            send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 99) >= drop_pct,
                      3'($urandom));
            n++;
        end
        hold_len = $urandom_range(0, int'(tracker.long_press_ticks) + 3);
        n = 0;
        while (tracker.busy() && n < hold_len)
        begin
            send_tick($urandom_range(0, 9) == 0, 1'b1, 3'($urandom));
            n++;
        end
        release_press();
    endtask

    initial
    begin
        int pick;
        int presses;

        tracker      = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = bdlp_pkg::REG_DEBOUNCE_TICKS;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b1;
        useful_ticks = 0;
        calm         = 1'b0;
        src_gap_pct  = 10;
        snk_gap_pct  = 10;
        snk_stall    = 0;
        quiet_cycles = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the registers: a short press judged at the default window.
        send_tick(1'b1, 1'b1, 3'($urandom));
        repeat (52) send_tick(1'b0, $urandom_range(0, 9) != 0, 3'($urandom));
        release_press();

        // Directed: short window and long-press time, beep selected.
        write_config(16'd2, 16'd1, 16'd5, 1'b0, 1'b1);
        // All colours held through to a long press.
        send_tick(1'b1, 1'b1, 3'b111);
        repeat (4) send_tick(1'b0, 1'b1, 3'b000);
        send_tick(1'b0, 1'b1, 3'b000);
        // Amber released early, with an edge while busy that must be ignored.
        send_tick(1'b1, 1'b1, 3'b010);
        send_tick(1'b1, 1'b1, 3'b101);
        send_tick(1'b0, 1'b0, 3'b000);
        // Too many low samples in the window: rejected.
        send_tick(1'b1, 1'b0, 3'b100);
        send_tick(1'b0, 1'b0, 3'b100);
        send_tick(1'b0, 1'b0, 3'b100);
        // Release with no colour latched.
        send_tick(1'b1, 1'b1, 3'b000);
        send_tick(1'b0, 1'b1, 3'b111);
        send_tick(1'b0, 1'b0, 3'b111);
        // Idle tick without an edge, then red alone.
        send_tick(1'b0, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b100);
        send_tick(1'b0, 1'b1, 3'b000);
        send_tick(1'b0, 1'b0, 3'b000);

        // Zero window and zero long-press time: the press ends on its edge tick.
        write_config(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 3'b001);
        send_tick(1'b1, 1'b0, 3'b011);
        send_tick(1'b1, 1'b0, 3'b110);

        // Random rounds over mostly small settings, the low extremes and the largest drop limit.
        useful_ticks = 0;
        while (useful_ticks < 480)
        begin
            if (useful_ticks > 380)
            begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 2))
                0:       src_gap_pct = 0;
                1:       src_gap_pct = 10;
                default: src_gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       snk_gap_pct = 0;
                1:       snk_gap_pct = 10;
                default: snk_gap_pct = 30;
            endcase
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                write_config(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
            end
            else if (pick == 1)
            begin
                write_config(16'($urandom_range(0, 6)), 16'hFFFF,
                             16'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
            end
            else if (pick == 2)
            begin
                write_config(16'd0, 16'd0, 16'($urandom_range(0, 15)),
                             1'($urandom), 1'($urandom));
            end
            else
            begin
                write_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                             16'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
            end
            presses = $urandom_range(3, 8);
            repeat (presses)
            begin
                idle_ticks();
                random_press();
                if ($urandom_range(0, 9) == 0)
                begin
                    drain_events();
                end
            end
        end

        // Let the last events come back, then a few cycles more.
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("button_debounce_long_press_tb OK");
        end
        else
        begin
            $display("button_debounce_long_press_tb NOT OK");
        end
        $finish;
    end

endmodule
